// ----- hw/rtl/lr_pkg.sv -----
`default_nettype none

package lr_pkg;

   // Longest emitted run of pixels for one command; longer lines are cut off.
   localparam int MAX_PIXELS = 64;
   localparam int CNT_BITS   = $clog2(MAX_PIXELS);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIFF = 4'b0010,
      ST_PLAN = 4'b0100,
      ST_RUN  = 4'b1000
   } lr_state_type;

   // Direction of one coordinate step
   typedef enum logic [1:0] {
      STEP_NONE = 2'b00,
      STEP_INC  = 2'b01,
      STEP_DEC  = 2'b10
   } step_type;

   typedef struct packed {
      logic load;   // capture endpoints
      logic diff;   // form spans and signs
      logic plan;   // pick start point, steps and decision terms
      logic step;   // emit current pixel, advance
   } lr_cmd_type;

   typedef struct packed {
      logic last_pixel;
   } lr_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/lr_ctrl.sv -----
`default_nettype none

module lr_ctrl
   import lr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire lr_status_type status,
   output lr_cmd_type         cmd,
   output logic               busy,
   output logic               rsp_valid
);

   lr_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (status.last_pixel) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RUN);

endmodule

`default_nettype wire

// ----- hw/rtl/lr_datapath.sv -----
`default_nettype none

module lr_datapath
   import lr_pkg::*;
#(
   parameter int COORD_BITS = 12
)
(
   input  wire logic                         clock,
   input  wire lr_cmd_type                   cmd,
   input  wire logic signed [COORD_BITS-1:0] req_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_end_y,
   output lr_status_type                     status,
   output logic signed [COORD_BITS-1:0]      rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]      rsp_pixel_y
);

   localparam int W = COORD_BITS;
   localparam int D = COORD_BITS + 3;   // decision term width

   function automatic logic [W-1:0] step_val(input step_type code);
      logic [W-1:0] v;
      case (code)
         STEP_INC: v = W'(1);
         STEP_DEC: v = '1;
         default:  v = '0;
      endcase
      return v;
   endfunction

   // endpoints
   logic signed [W-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   // spans and signs
   logic [W-1:0] adx_ff, ady_ff, adx_in, ady_in;
   logic         dxneg_ff, dyneg_ff, xeq_ff, yeq_ff;
   logic         dxneg_in, dyneg_in, xeq_in, yeq_in;
   // walk state
   logic [W-1:0]        x_ff, y_ff, x_in, y_in;
   step_type            mx_ff, my_ff, nx_ff, ny_ff, mx_in, my_in, nx_in, ny_in;
   logic [W-1:0]        remain_ff, remain_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic signed [D-1:0] df_ff, df_in, pos_ff, pos_in, neg_ff, neg_in;

   logic signed [W:0] dxf, dxr, dyf, dyr;
   logic signed [D-1:0] adx_e, ady_e, sh_df, sh_pos, st_df, st_pos;
   logic                swap_x, swap_y, df_pos;

   // Span stage: subtract both ways, keep the non-negative one
   always_comb begin
      dxf      = {x1_ff[W-1], x1_ff} - {x0_ff[W-1], x0_ff};
      dxr      = {x0_ff[W-1], x0_ff} - {x1_ff[W-1], x1_ff};
      dyf      = {y1_ff[W-1], y1_ff} - {y0_ff[W-1], y0_ff};
      dyr      = {y0_ff[W-1], y0_ff} - {y1_ff[W-1], y1_ff};
      dxneg_in = dxf[W];
      dyneg_in = dyf[W];
      adx_in   = dxf[W] ? dxr[W-1:0] : dxf[W-1:0];
      ady_in   = dyf[W] ? dyr[W-1:0] : dyf[W-1:0];
      xeq_in   = (x0_ff == x1_ff);
      yeq_in   = (y0_ff == y1_ff);
   end

   // Plan stage: both slope classes computed side by side, then select
   always_comb begin
      adx_e  = $signed({3'b000, adx_ff});
      ady_e  = $signed({3'b000, ady_ff});
      sh_df  = (ady_e <<< 1) - adx_e;
      sh_pos = (ady_e - adx_e) <<< 1;
      st_df  = (adx_e <<< 1) - ady_e;
      st_pos = (adx_e - ady_e) <<< 1;
      swap_x = dxneg_ff;
      swap_y = dyneg_ff;

      x_in      = x_ff;
      y_in      = y_ff;
      mx_in     = mx_ff;
      my_in     = my_ff;
      nx_in     = nx_ff;
      ny_in     = ny_ff;
      remain_in = remain_ff;
      cnt_in    = cnt_ff;
      df_in     = df_ff;
      pos_in    = pos_ff;
      neg_in    = neg_ff;
      df_pos    = (df_ff > 0);

      if (cmd.plan) begin
         mx_in  = STEP_NONE;
         my_in  = STEP_NONE;
         nx_in  = STEP_NONE;
         ny_in  = STEP_NONE;
         cnt_in = '0;
         if (xeq_ff) begin
            // vertical: lower y upward
            x_in      = x0_ff;
            y_in      = dyneg_ff ? y1_ff : y0_ff;
            my_in     = STEP_INC;
            remain_in = ady_ff;
            df_in     = -ady_e;
            pos_in    = -(ady_e <<< 1);
            neg_in    = '0;
         end else if (yeq_ff) begin
            // horizontal: lower x rightward
            x_in      = dxneg_ff ? x1_ff : x0_ff;
            y_in      = y0_ff;
            mx_in     = STEP_INC;
            remain_in = adx_ff;
            df_in     = -adx_e;
            pos_in    = -(adx_e <<< 1);
            neg_in    = '0;
         end else if (adx_ff == ady_ff) begin
            // exact diagonal: from start point, minor steps every pixel
            x_in      = x0_ff;
            y_in      = y0_ff;
            mx_in     = dxneg_ff ? STEP_DEC : STEP_INC;
            ny_in     = dyneg_ff ? STEP_DEC : STEP_INC;
            remain_in = adx_ff;
            df_in     = adx_e;
            pos_in    = '0;
            neg_in    = adx_e <<< 1;
         end else if (adx_ff > ady_ff) begin
            // shallow: from lower-x end
            x_in      = swap_x ? x1_ff : x0_ff;
            y_in      = swap_x ? y1_ff : y0_ff;
            mx_in     = STEP_INC;
            ny_in     = (dxneg_ff ^ dyneg_ff) ? STEP_DEC : STEP_INC;
            remain_in = adx_ff;
            df_in     = sh_df;
            pos_in    = sh_pos;
            neg_in    = ady_e <<< 1;
         end else begin
            // steep: from lower-y end
            x_in      = swap_y ? x1_ff : x0_ff;
            y_in      = swap_y ? y1_ff : y0_ff;
            my_in     = STEP_INC;
            nx_in     = (dxneg_ff ^ dyneg_ff) ? STEP_DEC : STEP_INC;
            remain_in = ady_ff;
            df_in     = st_df;
            pos_in    = st_pos;
            neg_in    = adx_e <<< 1;
         end
      end else if (cmd.step) begin
         x_in      = x_ff + step_val(mx_ff) + (df_pos ? step_val(nx_ff) : '0);
         y_in      = y_ff + step_val(my_ff) + (df_pos ? step_val(ny_ff) : '0);
         df_in     = df_ff + (df_pos ? pos_ff : neg_ff);
         remain_in = remain_ff - W'(1);
         cnt_in    = cnt_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x0_ff <= req_start_x;
         y0_ff <= req_start_y;
         x1_ff <= req_end_x;
         y1_ff <= req_end_y;
      end
      if (cmd.diff) begin
         adx_ff   <= adx_in;
         ady_ff   <= ady_in;
         dxneg_ff <= dxneg_in;
         dyneg_ff <= dyneg_in;
         xeq_ff   <= xeq_in;
         yeq_ff   <= yeq_in;
      end
      x_ff      <= x_in;
      y_ff      <= y_in;
      mx_ff     <= mx_in;
      my_ff     <= my_in;
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      remain_ff <= remain_in;
      cnt_ff    <= cnt_in;
      df_ff     <= df_in;
      pos_ff    <= pos_in;
      neg_ff    <= neg_in;
   end

   assign status.last_pixel = (remain_ff == '0) || (cnt_ff == CNT_BITS'(MAX_PIXELS - 1));
   assign rsp_pixel_x       = x_ff;
   assign rsp_pixel_y       = y_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/line_rasterizer.sv -----
// Line rasterizer: midpoint line walk, one pixel word per cycle.
// First pixel word: after the accepting edge the block passes through the span and plan
//   states, then shows the first pixel word.
// Each command: span and plan states, then a walk loop of up to 64 pixels that emits one
//   pixel per cycle; busy drops in the cycle after the last pixel word.
// The receiver cannot stall: each pixel word shows for exactly one cycle.
// Reset (synchronous, active high) returns the controller to idle; no other state.
`default_nettype none

module line_rasterizer
   import lr_pkg::*;
#(
   parameter int COORD_BITS = 12
)
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   // command channel
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [COORD_BITS-1:0] req_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_end_y,
   // pixel channel
   output logic                              rsp_valid,
   output logic signed [COORD_BITS-1:0]      rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]      rsp_pixel_y,
   output logic                              rsp_last
);

   lr_cmd_type    cmd;
   lr_status_type status;

   // Controller: idle, span, plan, then walk until the last pixel.
   lr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Datapath: hold endpoints, form spans, pick the slope class, step the walk.
   lr_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .status      (status),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y)
   );

   // Mark the final word only while a pixel is shown.
   assign rsp_last = rsp_valid & status.last_pixel;

endmodule

`default_nettype wire

// ----- hw/rtl/lr_checker.sv -----
`default_nettype none

module lr_checker #(
   parameter int COORD_BITS = 12
)
(
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic signed [COORD_BITS-1:0] req_start_x,
   input wire logic signed [COORD_BITS-1:0] req_start_y,
   input wire logic signed [COORD_BITS-1:0] req_end_x,
   input wire logic signed [COORD_BITS-1:0] req_end_y,
   input wire logic                         rsp_valid,
   input wire logic signed [COORD_BITS-1:0] rsp_pixel_x,
   input wire logic signed [COORD_BITS-1:0] rsp_pixel_y,
   input wire logic                         rsp_last
);

   // pixel words only inside a command
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("pixel word outside a command");

   // accepted command holds busy and shows no pixel yet
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted command not held");

   // pixels of one line come back to back
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("gap inside a line");

   // last pixel frees the block
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> (!busy && !rsp_valid))
      else $error("block still busy after last pixel");

endmodule

bind line_rasterizer lr_checker #(.COORD_BITS(COORD_BITS)) u_lr_checker (.*);

`default_nettype wire

// ----- sim/line_rasterizer_checker.sv -----
module line_rasterizer_checker
   import lr_pkg::*;
#(
   parameter int COORD_BITS = 12
)
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic                         busy,
   input  wire logic signed [COORD_BITS-1:0] req_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_end_y,
   input  wire logic                         rsp_valid,
   input  wire logic signed [COORD_BITS-1:0] rsp_pixel_x,
   input  wire logic signed [COORD_BITS-1:0] rsp_pixel_y,
   input  wire logic                         rsp_last,
   output int                                mismatch_count,
   output int                                pixels_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic                         last;
   } pixel_word_type;

   pixel_word_type expected_pixels[$];
   int             errors_seen   = 0;
   int             words_pending = 0;

   assign mismatch_count = errors_seen;
   assign pixels_pending = words_pending;

   function automatic int unit_step(input int v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   // Queue the pixel words of one line in drawing order, cut off at MAX_PIXELS.
   task automatic predict_line_pixels(input int x0, input int y0, input int x1, input int y1);
      int             adx, ady;
      int             x, y, mx, my, nx, ny;
      int             span, minor, term, i, n;
      pixel_word_type w;
      adx = (x1 > x0) ? x1 - x0 : x0 - x1;
      ady = (y1 > y0) ? y1 - y0 : y0 - y1;
      mx = 0; my = 0; nx = 0; ny = 0;
      if (x0 == x1) begin
         // vertical: bottom to top
         x = x0; y = (y0 < y1) ? y0 : y1;
         my = 1; span = ady; minor = 0;
      end else if (y0 == y1) begin
         // horizontal: left to right
         x = (x0 < x1) ? x0 : x1; y = y0;
         mx = 1; span = adx; minor = 0;
      end else if (adx == ady) begin
         // exact diagonal: from the start point, minor step on every pixel
         x = x0; y = y0;
         mx = unit_step(x1 - x0); ny = unit_step(y1 - y0);
         span = adx; minor = ady;
      end else if (adx > ady) begin
         // shallow: from the lower-x end
         if (x1 < x0) begin
            x = x1; y = y1; ny = unit_step(y0 - y1);
         end else begin
            x = x0; y = y0; ny = unit_step(y1 - y0);
         end
         mx = 1; span = adx; minor = ady;
      end else begin
         // steep: from the lower-y end
         if (y1 < y0) begin
            x = x1; y = y1; nx = unit_step(x0 - x1);
         end else begin
            x = x0; y = y0; nx = unit_step(x1 - x0);
         end
         my = 1; span = ady; minor = adx;
      end
      term = 2 * minor - span;
      n = 0;
      for (i = 0; i <= span && n < MAX_PIXELS; i++) begin
         w.x    = x[COORD_BITS-1:0];
         w.y    = y[COORD_BITS-1:0];
         w.last = (i == span) || (n == MAX_PIXELS - 1);
         expected_pixels.push_back(w);
         n++;
         x += mx;
         y += my;
         if (term > 0) begin
            x += nx;
            y += ny;
            term += 2 * (minor - span);
         end else begin
            term += 2 * minor;
         end
      end
   endtask

   always @(posedge clock) begin
      pixel_word_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (expected_pixels.size() == 0) begin
               errors_seen++;
               $display("%0t: unexpected pixel word: expected none, actual x=%0d y=%0d last=%b",
                        $time, rsp_pixel_x, rsp_pixel_y, rsp_last);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_x !== want.x || rsp_pixel_y !== want.y
                   || rsp_last !== want.last) begin
                  errors_seen++;
                  $display("%0t: pixel word mismatch: expected x=%0d y=%0d last=%b",
                           $time, want.x, want.y, want.last);
                  $display("%0t:                      actual   x=%0d y=%0d last=%b",
                           $time, rsp_pixel_x, rsp_pixel_y, rsp_last);
               end
            end
         end else if (rsp_valid !== 1'b0) begin
            errors_seen++;
            $display("%0t: pixel strobe unknown: expected 0 or 1, actual %b", $time, rsp_valid);
         end
         if (start === 1'b1 && busy === 1'b0)
            predict_line_pixels(req_start_x, req_start_y, req_end_x, req_end_y);
         words_pending = expected_pixels.size();
      end
   end

endmodule

// ----- sim/line_rasterizer_tb.sv -----
module line_rasterizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lr_pkg::*;

   localparam int COORD_BITS  = 12;
   localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));
   localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
   // Longest correct run: ~305 commands, each of up to 64 pixels plus setup and idle
   // gaps, stays well inside this limit; leave a wide margin.
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_LINES = 70;

   // Shapes drawn by the random part
   typedef enum int {
      SHAPE_ANY,
      SHAPE_POINT,
      SHAPE_HORIZ,
      SHAPE_VERT,
      SHAPE_DIAG,
      SHAPE_SLANT
   } line_shape_type;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic signed [COORD_BITS-1:0] req_start_x;
   logic signed [COORD_BITS-1:0] req_start_y;
   logic signed [COORD_BITS-1:0] req_end_x;
   logic signed [COORD_BITS-1:0] req_end_y;
   logic                         rsp_valid;
   logic signed [COORD_BITS-1:0] rsp_pixel_x;
   logic signed [COORD_BITS-1:0] rsp_pixel_y;
   logic                         rsp_last;

   int mismatch_count;
   int pixels_pending;
   int cycle_count = 0;
   // Chance in percent that the sender sits idle before its next command
   int idle_pct    = 0;

   line_rasterizer #(
      .COORD_BITS (COORD_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .rsp_valid   (rsp_valid),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y),
      .rsp_last    (rsp_last)
   );

   line_rasterizer_checker #(
      .COORD_BITS (COORD_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last       (rsp_last),
      .mismatch_count (mismatch_count),
      .pixels_pending (pixels_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end a hung run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Pick a coordinate: near either edge half the time, anywhere otherwise.
   function automatic int pick_coord();
      case ($urandom_range(0, 3))
         0:       return COORD_MIN + int'($urandom_range(0, 80));
         1:       return COORD_MAX - int'($urandom_range(0, 80));
         default: return COORD_MIN + int'($urandom_range(0, (1 << COORD_BITS) - 1));
      endcase
   endfunction

   // Offset a coordinate; mirror the offset when it would leave the field's range.
   function automatic int offset_coord(input int base, input int delta);
      int e;
      e = base + delta;
      if (e > COORD_MAX || e < COORD_MIN)
         e = base - delta;
      return e;
   endfunction

   // Nonzero span with random sign
   function automatic int pick_span();
      int d;
      d = int'($urandom_range(1, 70));
      return $urandom_range(0, 1) ? d : -d;
   endfunction

   // Issue one line command word. Optionally idle first, then hold start and the
   // endpoints until the block takes the word (start high, busy low at the edge).
   task automatic send_line(input int sx, input int sy, input int ex, input int ey);
      bit taken;
      taken = 1'b0;
      if ($urandom_range(1, 100) <= idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 79)) @(negedge clock);
      end
      @(negedge clock);
      start       <= 1'b1;
      req_start_x <= sx[COORD_BITS-1:0];
      req_start_y <= sy[COORD_BITS-1:0];
      req_end_x   <= ex[COORD_BITS-1:0];
      req_end_y   <= ey[COORD_BITS-1:0];
      while (!taken) begin
         @(posedge clock);
         taken = (busy === 1'b0);
      end
   endtask

   // Drop start and hold off until every predicted pixel word has come back.
   task automatic drain_pixels();
      @(negedge clock);
      start <= 1'b0;
      while (pixels_pending != 0) @(negedge clock);
   endtask

   initial begin
      int             phase_idle[4];
      int             p;
      int             x0, y0, x1, y1, d;
      line_shape_type shape;
      int             roll;

      phase_idle  = '{0, 55, 29, 0};
      reset       = 1'b1;
      start       = 1'b0;
      req_start_x = '0;
      req_start_y = '0;
      req_end_x   = '0;
      req_end_y   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, back to back.
      // Single points, including both corners of the coordinate range
      send_line(5, 5, 5, 5);
      send_line(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
      send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      // Horizontal and vertical, each given in both endpoint orders
      send_line(10, 3, 20, 3);
      send_line(20, -3, 10, -3);
      send_line(7, -5, 7, 5);
      send_line(7, 5, 7, -5);
      // Exact diagonals in all four directions
      send_line(0, 0, 6, 6);
      send_line(0, 0, -6, 6);
      send_line(0, 0, 6, -6);
      send_line(0, 0, -6, -6);
      // Shallow, rising and falling, both orders
      send_line(0, 0, 9, 4);
      send_line(9, 4, 0, 0);
      send_line(0, 0, 9, -4);
      send_line(9, -4, 0, 0);
      // Steep, rising and falling, both orders
      send_line(0, 0, 3, 10);
      send_line(3, 10, 0, 0);
      send_line(0, 0, -3, 10);
      send_line(-3, 10, 0, 0);
      // Long lines across the full range: cut off after the pixel limit
      send_line(COORD_MIN, 0, COORD_MAX, 0);
      send_line(0, COORD_MAX, 0, COORD_MIN);
      send_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
      send_line(COORD_MIN, COORD_MIN, COORD_MAX, 1000);
      // Exactly at the pixel limit, and one past it
      send_line(0, 0, MAX_PIXELS - 1, 0);
      send_line(0, 0, MAX_PIXELS, 0);

      // Let the directed lines finish before the random part.
      drain_pixels();

      // Random part: mostly short lines of every shape, some anywhere.
      for (p = 0; p < 4; p++) begin
         idle_pct = phase_idle[p];
         repeat (PHASE_LINES) begin
            roll = int'($urandom_range(0, 99));
            if (roll < 10)      shape = SHAPE_ANY;
            else if (roll < 18) shape = SHAPE_POINT;
            else if (roll < 30) shape = SHAPE_HORIZ;
            else if (roll < 42) shape = SHAPE_VERT;
            else if (roll < 54) shape = SHAPE_DIAG;
            else                shape = SHAPE_SLANT;
            x0 = pick_coord();
            y0 = pick_coord();
            case (shape)
               SHAPE_ANY: begin
                  x1 = pick_coord();
                  y1 = pick_coord();
               end
               SHAPE_POINT: begin
                  x1 = x0;
                  y1 = y0;
               end
               SHAPE_HORIZ: begin
                  x1 = offset_coord(x0, pick_span());
                  y1 = y0;
               end
               SHAPE_VERT: begin
                  x1 = x0;
                  y1 = offset_coord(y0, pick_span());
               end
               SHAPE_DIAG: begin
                  d  = int'($urandom_range(1, 70));
                  x1 = offset_coord(x0, $urandom_range(0, 1) ? d : -d);
                  y1 = offset_coord(y0, $urandom_range(0, 1) ? d : -d);
               end
               default: begin
                  x1 = offset_coord(x0, int'($urandom_range(0, 140)) - 70);
                  y1 = offset_coord(y0, int'($urandom_range(0, 140)) - 70);
               end
            endcase
            send_line(x0, y0, x1, y1);
         end
         // Pause between phases until every pixel word is back.
         drain_pixels();
      end

      // Wait out any stray word, then give the verdict.
      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
